/* src/pfds_pkg.sv */
package pfds_pkg;

  localparam int unsigned ADDR_BITS_DEF = 16;
  localparam int unsigned TGT_W         = 16;
  localparam int unsigned OP_W          = 4;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FETCH = 2'd1,
    PH_EXEC  = 2'd2
  } phase_t;

  localparam logic [OP_W-1:0] OP_STOP   = 4'h0;
  localparam logic [OP_W-1:0] OP_JUMP   = 4'h1;
  localparam logic [OP_W-1:0] OP_MOVE_A = 4'h2;
  localparam logic [OP_W-1:0] OP_MOVE_B = 4'h3;
  localparam logic [OP_W-1:0] OP_SOMA_A = 4'h4;
  localparam logic [OP_W-1:0] OP_SOMA_B = 4'h5;
  localparam logic [OP_W-1:0] OP_DEND_A = 4'h6;
  localparam logic [OP_W-1:0] OP_DEND_B = 4'h7;

  typedef struct packed {
    logic             sync_clear;
    logic             start_req;
    logic             stop;
    logic             unit_done;
    logic [OP_W-1:0]  word_opcode;
    logic             word_relative;
    logic [TGT_W-1:0] word_target;
  } pfds_in_t;

  typedef struct packed {
    logic [1:0]       phase;
    logic             in_idle;
    logic [TGT_W-1:0] fetch_address;
    logic             dendrite_start;
    logic             soma_start;
    logic             move_start;
    logic             fetch_done;
    logic             execute_done;
    logic             bad_opcode;
  } pfds_out_t;

endpackage

/* src/pfds_if.sv */
interface pfds_in_if;
  import pfds_pkg::*;
  logic     valid;
  logic     ready;
  pfds_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pfds_out_if;
  import pfds_pkg::*;
  logic      valid;
  logic      ready;
  pfds_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/pfds_core.sv */
module pfds_core #(
  parameter int unsigned ADDR_BITS = pfds_pkg::ADDR_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  pfds_pkg::pfds_in_t  item,
  output pfds_pkg::pfds_out_t res
);
  import pfds_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [ADDR_BITS-1:0]  pc_r, pc_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic                  rel_r, rel_nxt;
  logic [TGT_W-1:0]      tgt_r, tgt_nxt;
  logic                  stp_r, stp_nxt;
  logic                  den_nxt;
  logic                  soma_nxt;
  logic                  move_nxt;
  logic                  f_done, x_done, bad, finish, halt;

  always_comb begin
    phase_nxt = phase_r;
    pc_nxt    = pc_r;
    op_nxt    = op_r;
    rel_nxt   = rel_r;
    tgt_nxt   = tgt_r;
    stp_nxt   = stp_r;
    den_nxt   = 1'b0;
    soma_nxt  = 1'b0;
    move_nxt  = 1'b0;
    f_done    = 1'b0;
    x_done    = 1'b0;
    bad       = 1'b0;
    finish    = 1'b0;
    halt      = 1'b0;
    if (item.sync_clear) begin
      phase_nxt = PH_IDLE;
      pc_nxt    = '0;
      stp_nxt   = 1'b0;
    end else if (phase_r == PH_FETCH) begin
      if (item.stop) stp_nxt = 1'b1;
      op_nxt    = item.word_opcode;
      rel_nxt   = item.word_relative;
      tgt_nxt   = item.word_target;
      pc_nxt    = pc_r + ADDR_BITS'(1);
      f_done    = 1'b1;
      phase_nxt = PH_EXEC;
    end else if (phase_r == PH_EXEC) begin
      if (item.stop) stp_nxt = 1'b1;
      case (op_r)
        OP_DEND_A, OP_DEND_B: begin
          if (item.unit_done) finish = 1'b1;
          else den_nxt = 1'b1;
        end
        OP_SOMA_A, OP_SOMA_B: begin
          if (item.unit_done) finish = 1'b1;
          else soma_nxt = 1'b1;
        end
        OP_MOVE_A, OP_MOVE_B: begin
          if (item.unit_done) finish = 1'b1;
          else move_nxt = 1'b1;
        end
        OP_STOP: begin
          pc_nxt = '0;
          halt   = 1'b1;
          finish = 1'b1;
        end
        OP_JUMP: begin
          if (rel_r) pc_nxt = pc_r - ADDR_BITS'(1) + ADDR_BITS'(tgt_r);
          else pc_nxt = ADDR_BITS'(tgt_r);
          finish = 1'b1;
        end
        default: begin
          bad    = 1'b1;
          finish = 1'b1;
        end
      endcase
      if (finish) begin
        x_done = 1'b1;
        if (halt || stp_r || item.stop) begin
          phase_nxt = PH_IDLE;
          stp_nxt   = 1'b0;
        end else begin
          phase_nxt = PH_FETCH;
        end
      end
    end else begin
      stp_nxt = 1'b0;
      if (item.start_req) phase_nxt = PH_FETCH;
      else phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pc_r    <= '0;
      op_r    <= '0;
      rel_r   <= 1'b0;
      tgt_r   <= '0;
      stp_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pc_r    <= pc_nxt;
      op_r    <= op_nxt;
      rel_r   <= rel_nxt;
      tgt_r   <= tgt_nxt;
      stp_r   <= stp_nxt;
    end
  end

  // result shows the state after this item
  assign res.phase          = phase_nxt;
  assign res.in_idle        = (phase_nxt == PH_IDLE);
  assign res.fetch_address  = TGT_W'(pc_nxt);
  assign res.dendrite_start = den_nxt;
  assign res.soma_start     = soma_nxt;
  assign res.move_start     = move_nxt;
  assign res.fetch_done     = f_done;
  assign res.execute_done   = x_done;
  assign res.bad_opcode     = bad;

endmodule

/* src/primitive_fetch_dispatch_sequencer_unit.sv */
// Fetch/dispatch sequencer for a primitive core: each item is one controller
// tick carrying the control inputs and the fields of the word at the fetch
// address; each item gives exactly one result item with the phase, program
// counter, unit starts and completion pulses after that tick. An item passes
// an input register, one step of next-state logic and a result register;
// one item is accepted every cycle unless out_bus.ready holds the result
// register; the rate is set by the single state update per cycle in the
// core. The counter is ADDR_BITS wide and fetch_address shows its low 16 bits.
module primitive_fetch_dispatch_sequencer_unit #(
  parameter int unsigned ADDR_BITS = pfds_pkg::ADDR_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  pfds_in_if.sink    in_bus,
  pfds_out_if.source out_bus
);
  import pfds_pkg::*;

  logic      in_v_r;
  pfds_in_t  in_d_r;
  logic      out_v_r;
  pfds_out_t out_d_r;
  logic      adv;
  pfds_out_t res;

  assign adv          = in_v_r && (!out_v_r || out_bus.ready);
  assign in_bus.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_bus.ready) in_v_r <= in_bus.valid;
      if (adv) out_v_r <= 1'b1;
      else if (out_bus.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) in_d_r <= in_bus.data;
    if (adv) out_d_r <= res;
  end

  pfds_core #(
    .ADDR_BITS(ADDR_BITS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .step (adv),
    .item (in_d_r),
    .res  (res)
  );

  assign out_bus.valid = out_v_r;
  assign out_bus.data  = out_d_r;

`ifndef NO_ASSERTIONS
  a_one_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> $onehot0({out_d_r.dendrite_start, out_d_r.soma_start, out_d_r.move_start}))
    else $error("more than one unit start");

  a_bad_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_d_r.bad_opcode) |-> out_d_r.execute_done)
    else $error("bad opcode without completion");

  a_fetch_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_d_r.fetch_done) |-> (out_d_r.phase == PH_EXEC && !out_d_r.execute_done))
    else $error("fetch did not enter execute");

  a_idle_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_d_r.in_idle == (out_d_r.phase == PH_IDLE)))
    else $error("idle flag disagrees with phase");
`endif

endmodule

/* tb/pfds_seq_checker.sv */
module pfds_seq_checker (
  input  logic clk,
  input  logic rst_n,
  pfds_in_if   in_mon,
  pfds_out_if  out_mon,
  output int   fails,
  output int   backlog,
  output int   ticks_seen,
  output int   prims_done,
  output int   bad_seen,
  output int   jumps_seen
);
  import pfds_pkg::*;

  // controller copy
  phase_t          ph;
  logic [15:0]     pc;
  logic [OP_W-1:0] op_q;
  logic            rel_q;
  logic [15:0]     tgt_q;
  logic            stop_pend;
  logic            den_go;
  logic            soma_go;
  logic            move_go;

  pfds_out_t predicted_ticks[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fails++;
    if (fails <= 40) begin
      $display("MISMATCH t=%0t %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  function automatic pfds_out_t advance_controller(input pfds_in_t t);
    pfds_out_t r;
    logic      finished;
    logic      halted;
    r        = '0;
    finished = 1'b0;
    halted   = 1'b0;
    if (t.sync_clear) begin
      ph        = PH_IDLE;
      pc        = '0;
      stop_pend = 1'b0;
      den_go    = 1'b0;
      soma_go   = 1'b0;
      move_go   = 1'b0;
    end else begin
      case (ph)
        PH_FETCH: begin
          if (t.stop) stop_pend = 1'b1;
          den_go       = 1'b0;
          soma_go      = 1'b0;
          move_go      = 1'b0;
          op_q         = t.word_opcode;
          rel_q        = t.word_relative;
          tgt_q        = t.word_target;
          pc           = pc + 16'd1;
          r.fetch_done = 1'b1;
          ph           = PH_EXEC;
        end
        PH_EXEC: begin
          if (t.stop) stop_pend = 1'b1;
          den_go  = 1'b0;
          soma_go = 1'b0;
          move_go = 1'b0;
          case (op_q)
            OP_DEND_A, OP_DEND_B: begin
              if (t.unit_done) finished = 1'b1;
              else den_go = 1'b1;
            end
            OP_SOMA_A, OP_SOMA_B: begin
              if (t.unit_done) finished = 1'b1;
              else soma_go = 1'b1;
            end
            OP_MOVE_A, OP_MOVE_B: begin
              if (t.unit_done) finished = 1'b1;
              else move_go = 1'b1;
            end
            OP_STOP: begin
              pc       = '0;
              halted   = 1'b1;
              finished = 1'b1;
            end
            OP_JUMP: begin
              pc       = rel_q ? pc - 16'd1 + tgt_q : tgt_q;
              finished = 1'b1;
            end
            default: begin
              r.bad_opcode = 1'b1;
              finished     = 1'b1;
            end
          endcase
          if (finished) begin
            r.execute_done = 1'b1;
            if (halted || stop_pend) begin
              ph        = PH_IDLE;
              stop_pend = 1'b0;
            end else begin
              ph = PH_FETCH;
            end
          end
        end
        default: begin
          ph        = t.start_req ? PH_FETCH : PH_IDLE;
          stop_pend = 1'b0;
          den_go    = 1'b0;
          soma_go   = 1'b0;
          move_go   = 1'b0;
        end
      endcase
    end
    r.phase          = ph;
    r.in_idle        = (ph == PH_IDLE);
    r.fetch_address  = pc;
    r.dendrite_start = den_go;
    r.soma_start     = soma_go;
    r.move_start     = move_go;
    return r;
  endfunction

  always @(posedge clk) begin
    pfds_out_t want;
    pfds_out_t got;
    if (!rst_n) begin
      ph         = PH_IDLE;
      pc         = '0;
      op_q       = '0;
      rel_q      = 1'b0;
      tgt_q      = '0;
      stop_pend  = 1'b0;
      den_go     = 1'b0;
      soma_go    = 1'b0;
      move_go    = 1'b0;
      fails      = 0;
      ticks_seen = 0;
      prims_done = 0;
      bad_seen   = 0;
      jumps_seen = 0;
      predicted_ticks.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (!in_mon.data.sync_clear && ph == PH_EXEC && op_q == OP_JUMP) jumps_seen++;
        want = advance_controller(in_mon.data);
        predicted_ticks.push_back(want);
        ticks_seen++;
        if (want.execute_done) prims_done++;
        if (want.bad_opcode) bad_seen++;
      end
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (predicted_ticks.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(got), '0);
        end else begin
          want = predicted_ticks.pop_front();
          check_field("phase", 32'(got.phase), 32'(want.phase));
          check_field("in_idle", 32'(got.in_idle), 32'(want.in_idle));
          check_field("fetch_address", 32'(got.fetch_address), 32'(want.fetch_address));
          check_field("dendrite_start", 32'(got.dendrite_start), 32'(want.dendrite_start));
          check_field("soma_start", 32'(got.soma_start), 32'(want.soma_start));
          check_field("move_start", 32'(got.move_start), 32'(want.move_start));
          check_field("fetch_done", 32'(got.fetch_done), 32'(want.fetch_done));
          check_field("execute_done", 32'(got.execute_done), 32'(want.execute_done));
          check_field("bad_opcode", 32'(got.bad_opcode), 32'(want.bad_opcode));
        end
      end
    end
    backlog = predicted_ticks.size();
  end

endmodule

/* tb/primitive_fetch_dispatch_sequencer_unit_test.sv */
module primitive_fetch_dispatch_sequencer_unit_test;
  import pfds_pkg::*;

  localparam int STALL_LIMIT  = 500;
  localparam int RANDOM_TICKS = 1300;

  logic clk = 1'b0;
  logic rst_n;
  logic idle_on = 1'b1;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   fails;
  int   backlog;
  int   ticks_seen;
  int   prims_done;
  int   bad_seen;
  int   jumps_seen;

  pfds_in_if  in_bus ();
  pfds_out_if out_bus ();

  primitive_fetch_dispatch_sequencer_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  pfds_seq_checker seq_watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .fails      (fails),
    .backlog    (backlog),
    .ticks_seen (ticks_seen),
    .prims_done (prims_done),
    .bad_seen   (bad_seen),
    .jumps_seen (jumps_seen)
  );

  always #6 clk = ~clk;

  // result side back-pressure
  always @(posedge clk) begin
    if (out_bus.valid && out_bus.ready) begin
      stall_left = idle_on ? $urandom_range(0, 7) : 0;
    end
    if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic pfds_in_t make_tick(input logic clr, input logic go, input logic stp,
                                         input logic done, input logic [OP_W-1:0] op,
                                         input logic rel, input logic [15:0] tgt);
    pfds_in_t t;
    t.sync_clear    = clr;
    t.start_req     = go;
    t.stop          = stp;
    t.unit_done     = done;
    t.word_opcode   = op;
    t.word_relative = rel;
    t.word_target   = tgt;
    return t;
  endfunction

  task automatic send_tick(input pfds_in_t t);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.data  <= t;
    in_bus.valid <= 1'b1;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  function automatic pfds_in_t random_tick();
    pfds_in_t    t;
    int          pick;
    logic [15:0] tgt;
    pick = $urandom_range(0, 99);
    if (pick < 70) t.word_opcode = OP_W'($urandom_range(2, 7));
    else if (pick < 85) t.word_opcode = OP_W'($urandom_range(0, 1));
    else t.word_opcode = OP_W'($urandom_range(8, 15));
    pick = $urandom_range(0, 9);
    if (pick == 0) tgt = 16'h0000;
    else if (pick == 1) tgt = 16'hFFFF;
    else if (pick < 5) tgt = 16'($urandom_range(0, 31));
    else tgt = 16'($urandom());
    t.sync_clear    = ($urandom_range(0, 63) == 0);
    t.start_req     = 1'($urandom_range(0, 1));
    t.stop          = ($urandom_range(0, 15) == 0);
    t.unit_done     = ($urandom_range(0, 2) == 0);
    t.word_relative = 1'($urandom_range(0, 1));
    t.word_target   = tgt;
    return t;
  endfunction

  initial begin
    rst_n         <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.data   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stop while idle, then start
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b0, OP_STOP, 1'b0, 16'h0000));
    send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0, OP_STOP, 1'b0, 16'h0000));
    // absolute jump to top of range, next fetch wraps the counter
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, OP_JUMP, 1'b0, 16'hFFFF));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, OP_STOP, 1'b0, 16'h0000));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, OP_DEND_A, 1'b1, 16'h1234));
    // unit done on first execute tick
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1, OP_STOP, 1'b0, 16'h0000));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, OP_SOMA_B, 1'b0, 16'hA5A5));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, OP_STOP, 1'b0, 16'h0000));
    // stop during execute is held until done
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b0, OP_STOP, 1'b0, 16'h0000));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1, OP_STOP, 1'b0, 16'h0000));
    send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0, OP_STOP, 1'b0, 16'h0000));
    // stop during fetch
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b0, OP_MOVE_B, 1'b1, 16'hFFFF));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, OP_STOP, 1'b0, 16'h0000));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1, OP_STOP, 1'b0, 16'h0000));
    send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0, OP_STOP, 1'b0, 16'h0000));
    // relative jump by zero steps back onto the jump itself
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, OP_JUMP, 1'b1, 16'h0000));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, OP_STOP, 1'b0, 16'h0000));
    // unsupported opcode
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 4'hF, 1'b0, 16'h0000));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, OP_STOP, 1'b0, 16'h0000));
    // relative jump with wraparound
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, OP_JUMP, 1'b1, 16'hFFFF));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, OP_STOP, 1'b0, 16'h0000));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, OP_SOMA_A, 1'b0, 16'h0001));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, OP_STOP, 1'b0, 16'h0000));
    // clear while a unit is running, every other field high
    send_tick(make_tick(1'b1, 1'b1, 1'b1, 1'b1, 4'hF, 1'b1, 16'hFFFF));
    send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0, OP_STOP, 1'b0, 16'h0000));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, OP_STOP, 1'b1, 16'hFFFF));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 4'h8, 1'b0, 16'h0000));

    for (int n = 0; n < RANDOM_TICKS; n++) begin
      if (n % 150 == 0) idle_on = 1'($urandom_range(0, 1));
      send_tick(random_tick());
    end
    in_bus.valid <= 1'b0;

    while (backlog != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d ticks: %0d primitives completed, %0d jumps, %0d unsupported opcodes",
             ticks_seen, prims_done, jumps_seen, bad_seen);
    $display("with random gaps on both channels and stretches of full rate");
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
src/pfds_pkg.sv
src/pfds_if.sv
src/pfds_core.sv
src/primitive_fetch_dispatch_sequencer_unit.sv
tb/pfds_seq_checker.sv
tb/primitive_fetch_dispatch_sequencer_unit_test.sv
